// ===== sv/drs_pkg.sv =====
// Shared types and constants for the DHCP reply option scanner.
`timescale 1ns / 1ps

package drs_pkg;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_END      = 8'hFF;
    localparam logic [7:0] MSG_OFFER    = 8'd2;
    localparam logic [7:0] MSG_ACK      = 8'd5;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [2:0] {
        PH_TYPE  = 3'b001,
        PH_LEN   = 3'b010,
        PH_VALUE = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_BOUND   = 2'd2
    } action_t;

    typedef struct packed {
        logic [31:0] offered_addr;
        logic        is_reply;
        logic        last_byte;
        logic        first_byte;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic        addr_bound;
        logic [31:0] host_addr;
        logic [31:0] request_addr;
        action_t     action;
    } result_t;

endpackage

// ===== sv/drs_scan.sv =====
// Option list walker: per-packet scan state, host address store and result build.
`timescale 1ns / 1ps

module drs_scan
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  drs_pkg::item_t  item,
    output logic            res_valid,
    output drs_pkg::result_t result
);

    drs_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      left_reg, left_next;
    logic            target_reg, target_next;
    logic            found_reg, found_next;
    logic [7:0]      msg_reg, msg_next;
    logic            done_reg, done_next;
    logic [31:0]     stored_reg, stored_next;
    logic            bound_reg, bound_next;

    logic       end_seen;
    logic [7:0] left_dec;

    always_comb
    begin
        // A first byte starts from a clean per-packet state.
        phase_next  = item.first_byte ? drs_pkg::PH_TYPE : phase_reg;
        left_next   = item.first_byte ? 8'd0 : left_reg;
        target_next = item.first_byte ? 1'b0 : target_reg;
        found_next  = item.first_byte ? 1'b0 : found_reg;
        msg_next    = item.first_byte ? 8'd0 : msg_reg;
        done_next   = item.first_byte ? 1'b0 : done_reg;
        stored_next = stored_reg;
        bound_next  = bound_reg;
        end_seen    = 1'b0;
        left_dec    = left_next - 8'd1;
        res_valid   = 1'b0;
        result.action       = drs_pkg::ACT_NONE;
        result.request_addr = 32'd0;

        if (!done_next)
        begin
            unique case (phase_next)
                drs_pkg::PH_LEN:
                begin
                    left_next = item.data_byte;
                    if (item.data_byte == 8'd0)
                    begin
                        phase_next  = drs_pkg::PH_TYPE;
                        target_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = drs_pkg::PH_VALUE;
                    end
                end
                drs_pkg::PH_VALUE:
                begin
                    if (target_next && !found_next)
                    begin
                        msg_next   = item.data_byte;
                        found_next = 1'b1;
                    end
                    target_next = 1'b0;
                    left_next   = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = drs_pkg::PH_TYPE;
                    end
                end
                default:
                begin
                    phase_next = drs_pkg::PH_TYPE;
                    if (item.data_byte == drs_pkg::OPT_END)
                    begin
                        end_seen = 1'b1;
                    end
                    else if (item.data_byte != drs_pkg::OPT_PAD)
                    begin
                        target_next = (item.data_byte == drs_pkg::OPT_MSG_TYPE) && !found_next;
                        phase_next  = drs_pkg::PH_LEN;
                    end
                end
            endcase

            if (end_seen || item.last_byte)
            begin
                done_next = 1'b1;
                res_valid = 1'b1;
                if (item.is_reply && found_next)
                begin
                    if (msg_next == drs_pkg::MSG_OFFER)
                    begin
                        result.action       = drs_pkg::ACT_REQUEST;
                        result.request_addr = item.offered_addr;
                    end
                    else if (msg_next == drs_pkg::MSG_ACK)
                    begin
                        result.action = drs_pkg::ACT_BOUND;
                        stored_next   = item.offered_addr;
                        bound_next    = 1'b1;
                    end
                end
            end
        end

        result.host_addr  = stored_next;
        result.addr_bound = bound_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= drs_pkg::PH_TYPE;
            left_reg   <= 8'd0;
            target_reg <= 1'b0;
            found_reg  <= 1'b0;
            msg_reg    <= 8'd0;
            done_reg   <= 1'b0;
            stored_reg <= 32'd0;
            bound_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            target_reg <= target_next;
            found_reg  <= found_next;
            msg_reg    <= msg_next;
            done_reg   <= done_next;
            stored_reg <= stored_next;
            bound_reg  <= bound_next;
        end
    end

endmodule

// ===== sv/dhcp_reply_option_scan_top.sv =====
// Top level of the DHCP reply option scanner with stream ports.
// Usage:
//   Feed the option bytes of each packet, starting after the magic cookie, one
//   beat per byte on the s_axis group. tuser[0] marks the first byte of a packet,
//   tuser[1] says the packet is a reply, tlast marks the last byte available.
//   One result beat per packet leaves on m_axis, when the end option arrives or
//   at tlast, whichever comes first; further bytes of that packet are dropped.
// Path: the closing byte is taken into an input register and scanned there;
//   its result beat is registered into the output register once m_axis is
//   free, and is then valid on m_axis.
// Throughput: one byte per cycle while no result beat waits on m_axis, limited
//   by the scan step that updates the option walk state.
// Reset: clears the scan state, the stored host address and the bound flag;
//   no beat is held on either side.
// Stall: while m_axis is held off with a result waiting, the input register takes
//   a byte only while empty; once full, s_axis_tready is low until the result leaves.
`timescale 1ns / 1ps

module dhcp_reply_option_scan_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // data_byte [7:0], offered_addr [39:8]
    input  logic [drs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // first_byte [0], is_reply [1]
    input  logic [drs_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // action [1:0], request_addr [33:2], host_addr [65:34], addr_bound [66], zero [71:67]
    output logic [drs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic             in_valid_reg;
    drs_pkg::item_t   in_item_reg;
    logic             out_valid_reg, out_valid_next;
    drs_pkg::result_t out_res_reg;

    logic             out_free;
    logic             advance;
    logic             res_valid;
    drs_pkg::result_t res;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.data_byte    <= s_axis_tdata[7:0];
            in_item_reg.offered_addr <= s_axis_tdata[39:8];
            in_item_reg.first_byte   <= s_axis_tuser[0];
            in_item_reg.is_reply     <= s_axis_tuser[1];
            in_item_reg.last_byte    <= s_axis_tlast;
        end
    end

    drs_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .result    (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = advance && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg.addr_bound, out_res_reg.host_addr,
                            out_res_reg.request_addr, out_res_reg.action};

`ifndef SYNTHESIS
    a_bound_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.action == drs_pkg::ACT_BOUND) |-> out_res_reg.addr_bound)
        else $error("bound result without bound flag");

    a_no_req_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.action != drs_pkg::ACT_REQUEST)
            |-> (out_res_reg.request_addr == 32'd0))
        else $error("request address set without request action");

    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_res_reg.action == drs_pkg::ACT_NONE ||
                           out_res_reg.action == drs_pkg::ACT_REQUEST ||
                           out_res_reg.action == drs_pkg::ACT_BOUND))
        else $error("undefined action code");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input beat lost while result stalled");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the DHCP reply option scanner stream top level.
`timescale 1ns / 1ps

module tb_top;

    import drs_pkg::*;

    localparam int SCAN_TARGET = 1400;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // option walk state of the predictor
    phase_t      walk_phase = PH_TYPE;
    logic [7:0]  len_left = '0;
    bit          in_type_opt = 1'b0;
    bit          type_seen = 1'b0;
    logic [7:0]  msg_code = '0;
    bit          closed = 1'b0;
    logic [31:0] host_q = '0;
    bit          bound_q = 1'b0;

    result_t     result_q[$];
    logic [7:0]  pkt_bytes[$];

    bit          steady_src = 1'b0;
    bit          steady_sink = 1'b0;
    int          sink_hold = 0;
    int          mismatches = 0;
    int          packets_sent = 0;
    int          items_sent = 0;
    int          bytes_scanned = 0;
    int          results_checked = 0;
    int          n_requests = 0;
    int          n_bindings = 0;
    result_t     want;
    result_t     got;

    dhcp_reply_option_scan_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] exp_v);
        if (mismatches < 30)
        begin
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what,
                     got_v, exp_v);
        end
        mismatches++;
    endtask

    // Advance the option walk by one accepted byte and queue the result it closes.
    task automatic scan_byte(input item_t it);
        result_t res;
        bit      closes;
        closes = 1'b0;
        if (it.first_byte)
        begin
            walk_phase  = PH_TYPE;
            len_left    = '0;
            in_type_opt = 1'b0;
            type_seen   = 1'b0;
            msg_code    = '0;
            closed      = 1'b0;
        end
        if (closed)
            return;
        bytes_scanned++;
        case (walk_phase)
            PH_LEN:
            begin
                len_left = it.data_byte;
                if (it.data_byte == 8'd0)
                begin
                    walk_phase  = PH_TYPE;
                    in_type_opt = 1'b0;
                end
                else
                begin
                    walk_phase = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (in_type_opt && !type_seen)
                begin
                    msg_code  = it.data_byte;
                    type_seen = 1'b1;
                end
                in_type_opt = 1'b0;
                len_left    = len_left - 8'd1;
                if (len_left == 8'd0)
                    walk_phase = PH_TYPE;
            end
            default:
            begin
                walk_phase = PH_TYPE;
                if (it.data_byte == OPT_END)
                begin
                    closes = 1'b1;
                end
                else if (it.data_byte != OPT_PAD)
                begin
                    in_type_opt = (it.data_byte == OPT_MSG_TYPE) && !type_seen;
                    walk_phase  = PH_LEN;
                end
            end
        endcase
        if (!closes && !it.last_byte)
            return;
        closed           = 1'b1;
        res.action       = ACT_NONE;
        res.request_addr = '0;
        if (it.is_reply && type_seen)
        begin
            if (msg_code == MSG_OFFER)
            begin
                res.action       = ACT_REQUEST;
                res.request_addr = it.offered_addr;
                n_requests++;
            end
            else if (msg_code == MSG_ACK)
            begin
                res.action = ACT_BOUND;
                host_q     = it.offered_addr;
                bound_q    = 1'b1;
                n_bindings++;
            end
        end
        res.host_addr  = host_q;
        res.addr_bound = bound_q;
        result_q.push_back(res);
    endtask

    // Present one byte beat and hold it until taken. tvalid stays high afterwards
    // so that a zero gap keeps the stream back to back.
    task automatic send_item(input item_t it);
        int gap;
        gap = steady_src ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.offered_addr, it.data_byte};
        s_axis_tuser  <= {it.is_reply, it.first_byte};
        s_axis_tlast  <= it.last_byte;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        scan_byte(it);
    endtask

    // Send pkt_bytes as one packet; tlast goes on index last_at (none if negative).
    task automatic send_packet(input int last_at, input bit reply, input logic [31:0] addr);
        item_t it;
        for (int i = 0; i < pkt_bytes.size(); i++)
        begin
            it.data_byte    = pkt_bytes[i];
            it.first_byte   = (i == 0);
            it.last_byte    = (i == last_at);
            it.is_reply     = reply;
            it.offered_addr = addr;
            send_item(it);
        end
        packets_sent++;
    endtask

    // Hold off the sender until every queued result has left the block.
    task automatic wait_for_results;
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_offer;
        // end option and tlast on the same byte, all-ones address
        pkt_bytes = {OPT_MSG_TYPE, 8'd1, MSG_OFFER, OPT_END};
        send_packet(3, 1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_ack_binding;
        // pad, then an empty message-type option that must not count
        pkt_bytes = {OPT_PAD, OPT_MSG_TYPE, 8'd0, OPT_MSG_TYPE, 8'd1, MSG_ACK, OPT_END};
        send_packet(-1, 1'b1, 32'h0000_0000);
    endtask

    task automatic test_not_reply;
        pkt_bytes = {OPT_MSG_TYPE, 8'd1, MSG_ACK, OPT_END};
        send_packet(3, 1'b0, 32'hC0A8_0117);
    endtask

    task automatic test_repeated_type;
        // first message type is unknown and wins; packet cut short by tlast
        pkt_bytes = {OPT_MSG_TYPE, 8'd1, 8'd9, OPT_MSG_TYPE, 8'd1, MSG_OFFER};
        send_packet(5, 1'b1, 32'h0A00_0001);
    endtask

    task automatic test_trailing_bytes;
        // no message type before the end option; bytes after it are dropped
        pkt_bytes = {OPT_END, OPT_MSG_TYPE, 8'd1, MSG_OFFER};
        send_packet(3, 1'b1, 32'h0A00_0002);
    endtask

    task automatic test_random_packets;
        int          n_opt;
        int          kind;
        int          len;
        int          r;
        int          last_at;
        int          pkt_idx;
        bit          drained;
        logic [7:0]  t;
        item_t       it;
        pkt_idx = 0;
        drained = 1'b0;
        while (items_sent < SCAN_TARGET)
        begin
            if (pkt_idx % 20 == 0)
            begin
                steady_src  = ($urandom_range(0, 3) == 0);
                steady_sink = ($urandom_range(0, 3) == 0);
            end
            pkt_idx++;
            if (!drained && items_sent > SCAN_TARGET / 2)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                wait_for_results();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: unrelated flags and fields on every beat
                repeat ($urandom_range(1, 8))
                begin
                    it.data_byte    = 8'($urandom_range(0, 255));
                    it.first_byte   = ($urandom_range(0, 3) == 0);
                    it.last_byte    = ($urandom_range(0, 3) == 0);
                    it.is_reply     = ($urandom_range(0, 1) == 1);
                    it.offered_addr = $urandom;
                    send_item(it);
                end
                continue;
            end
            pkt_bytes.delete();
            n_opt = $urandom_range(0, 5);
            repeat (n_opt)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    pkt_bytes.push_back(OPT_PAD);
                end
                else if (kind <= 4)
                begin
                    pkt_bytes.push_back(OPT_MSG_TYPE);
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 1;
                    pkt_bytes.push_back(len[7:0]);
                    repeat (len)
                    begin
                        r = $urandom_range(0, 4);
                        if (r < 2)
                            pkt_bytes.push_back(MSG_OFFER);
                        else if (r < 4)
                            pkt_bytes.push_back(MSG_ACK);
                        else
                            pkt_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                end
                else
                begin
                    t = 8'($urandom_range(1, 254));
                    if (t == OPT_MSG_TYPE)
                        t = t + 8'd1;
                    pkt_bytes.push_back(t);
                    len = ($urandom_range(0, 199) == 0) ? 255 : $urandom_range(0, 6);
                    pkt_bytes.push_back(len[7:0]);
                    repeat (len)
                        pkt_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 9) != 0)
                pkt_bytes.push_back(OPT_END);
            repeat ($urandom_range(0, 2))
                pkt_bytes.push_back(8'($urandom_range(0, 255)));
            if (pkt_bytes.size() == 0)
                pkt_bytes.push_back(8'($urandom_range(0, 255)));
            r = $urandom_range(0, 9);
            if (r < 7)
                last_at = pkt_bytes.size() - 1;
            else if (r < 9)
                last_at = $urandom_range(0, pkt_bytes.size() - 1);
            else
                last_at = -1;
            send_packet(last_at, ($urandom_range(0, 4) != 0), $urandom);
        end
        steady_src  = 1'b0;
        steady_sink = 1'b0;
    endtask

    // Take result beats with random stalls and compare against the oldest prediction.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[66:0]);
            if (result_q.size() == 0)
            begin
                report_mismatch("result beat with none expected", m_axis_tdata[31:0], '0);
            end
            else
            begin
                want = result_q.pop_front();
                if (got.action !== want.action)
                    report_mismatch("action", 32'(got.action), 32'(want.action));
                if (got.request_addr !== want.request_addr)
                    report_mismatch("request_addr", got.request_addr, want.request_addr);
                if (got.host_addr !== want.host_addr)
                    report_mismatch("host_addr", got.host_addr, want.host_addr);
                if (got.addr_bound !== want.addr_bound)
                    report_mismatch("addr_bound", 32'(got.addr_bound), 32'(want.addr_bound));
                if (m_axis_tdata[71:67] !== '0)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[71:67]), '0);
            end
            results_checked++;
            sink_hold = steady_sink ? 0 : $urandom_range(0, 14);
            if (sink_hold > 0)
                m_axis_tready <= 1'b0;
        end
        else if (!m_axis_tready)
        begin
            if (sink_hold > 0)
                sink_hold--;
            if (sink_hold == 0)
                m_axis_tready <= 1'b1;
        end
        else if (!steady_sink && $urandom_range(0, 7) == 0)
        begin
            // stall with nothing pending as well
            sink_hold = $urandom_range(1, 14);
            m_axis_tready <= 1'b0;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_offer();
        test_ack_binding();
        test_not_reply();
        test_repeated_type();
        test_trailing_bytes();
        test_random_packets();
        wait_for_results();
        repeat (8) @(posedge clk);
        $display("Ran %0d packets plus noise, %0d byte beats, %0d option bytes scanned.",
                 packets_sent, items_sent, bytes_scanned);
        $display("Checked %0d results: %0d address requests, %0d bindings, %0d mismatches.",
                 results_checked, n_requests, n_bindings, mismatches);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout: %0d results still outstanding.", result_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
